// ----- rtl/core/emoji_cluster_segmenter_assert.svh -----
// Assertion macros used by the back end of the emoji cluster segmenter RTL.
`ifndef EMOJI_CLUSTER_SEGMENTER_ASSERT_SVH
`define EMOJI_CLUSTER_SEGMENTER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checks that an expression holds at every clock edge outside reset.
`define ECS_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("ecs assertion failed");
// Checks that a condition is followed by a consequence in the next cycle.
`define ECS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecs assertion failed");
`else
`define ECS_ASSERT_ALWAYS(label, expr)
`define ECS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/ecs_pkg.sv -----
// Shared types and constants of the emoji cluster segmenter.
`default_nettype none

package ecs_pkg;

  localparam int POS_W       = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [POS_W-1:0] pos_t;

  // Character classes of one code point.
  typedef struct packed {
    logic keybase;
    logic ri;
    logic base;
    logic vs;
    logic modifier;
    logic tag;
    logic tag_end;
    logic zwj;
    logic keycap;
  } cls_t;

  // One accepted code unit, as the front hands it to the back.
  typedef struct packed {
    logic lone;      // a held high surrogate turned out to be unpaired
    logic ev_valid;  // a code point is to be fed
    cls_t cls;
    pos_t start;
    pos_t after;
    logic eot;
  } q_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/ecs_front.sv -----
// Front end: accepts code units, joins surrogate pairs and classifies code points.
`default_nettype none

module ecs_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [15:0]       s_axis_tdata,  // code_unit
  input  wire logic              s_axis_tlast,  // end_of_text
  output logic                   push,
  output ecs_pkg::q_entry_t      entry,
  input  wire logic              q_full
);
  import ecs_pkg::*;

  localparam logic [20:0] CP_ZWJ     = 21'h0200D;
  localparam logic [20:0] CP_KEYCAP  = 21'h020E3;
  localparam logic [20:0] CP_TAG_END = 21'h0E007F;
  localparam logic [20:0] CP_SUPP    = 21'h10000;

  function automatic cls_t classify(input logic [20:0] c);
    cls_t r;
    r.keybase  = (c >= 21'h30 && c <= 21'h39) || c == 21'h23 || c == 21'h2A;
    r.ri       = c >= 21'h1F1E6 && c <= 21'h1F1FF;
    r.base     = (c >= 21'h1F000 && c <= 21'h1FAFF) || (c >= 21'h1FC00 && c <= 21'h1FFFF) ||
                 (c >= 21'h2600 && c <= 21'h27BF) || (c >= 21'h2B00 && c <= 21'h2BFF) ||
                 (c >= 21'h2300 && c <= 21'h23FF) ||
                 c == 21'h00A9 || c == 21'h00AE || c == 21'h203C || c == 21'h2049 ||
                 c == 21'h2122 || c == 21'h2139 || c == 21'h24C2 || c == 21'h3030 ||
                 c == 21'h303D || c == 21'h3297 || c == 21'h3299 ||
                 (c >= 21'h2194 && c <= 21'h21AA) || (c >= 21'h25AA && c <= 21'h25AB) ||
                 c == 21'h25B6 || c == 21'h25C0 || (c >= 21'h25FB && c <= 21'h25FE);
    r.vs       = c == 21'hFE0E || c == 21'hFE0F || (c >= 21'hE0100 && c <= 21'hE01EF);
    r.modifier = c >= 21'h1F3FB && c <= 21'h1F3FF;
    r.tag      = c >= 21'hE0020 && c <= CP_TAG_END;
    r.tag_end  = c == CP_TAG_END;
    r.zwj      = c == CP_ZWJ;
    r.keycap   = c == CP_KEYCAP;
    return r;
  endfunction

  pos_t       pos;
  logic       held_valid;
  logic [9:0] held_bits;

  logic [15:0] u;
  logic        eot;
  logic        is_low;
  logic        is_high;
  logic        joined;
  logic        hold_next;
  pos_t        prev;
  pos_t        next;
  logic [20:0] cp;

  assign u       = s_axis_tdata;
  assign eot     = s_axis_tlast;
  assign is_low  = u[15:10] == 6'b110111;
  assign is_high = u[15:10] == 6'b110110;
  assign prev    = pos - POS_W'(1);
  assign next    = pos + POS_W'(1);
  assign joined  = held_valid && is_low;
  // A high surrogate is held back unless the text ends on it.
  assign hold_next = !joined && is_high && !eot;
  assign cp = joined ? (CP_SUPP + {1'b0, held_bits, u[9:0]}) : {5'b0, u};

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    entry.lone     = held_valid && !is_low;
    entry.ev_valid = !hold_next;
    entry.cls      = classify(cp);
    entry.start    = joined ? prev : pos;
    entry.after    = next;
    entry.eot      = eot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      held_valid <= 1'b0;
    end else if (push) begin
      pos        <= eot ? '0 : next;
      held_valid <= hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && hold_next) begin
      held_bits <= u[9:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ecs_queue.sv -----
// Short FIFO between the classifying front end and the parsing back end.
`default_nettype none

module ecs_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ecs_pkg::q_entry_t din,
  output logic                   full,
  input  wire logic              pop,
  output ecs_pkg::q_entry_t      dout,
  output logic                   empty
);
  import ecs_pkg::*;

  q_entry_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ecs_back.sv -----
// Back end: cluster parser and result buffer of the emoji cluster segmenter.
`default_nettype none
`include "emoji_cluster_segmenter_assert.svh"

module ecs_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire ecs_pkg::q_entry_t head,
  output logic                   pop,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [63:0]            m_axis_tdata,  // range_start, range_length
  output logic                   m_axis_tlast   // last_result
);
  import ecs_pkg::*;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_KEY1  = 4'd1;
  localparam logic [3:0] PH_KEY2  = 4'd2;
  localparam logic [3:0] PH_RI1   = 4'd3;
  localparam logic [3:0] PH_BVS   = 4'd4;
  localparam logic [3:0] PH_BMOD  = 4'd5;
  localparam logic [3:0] PH_BTAG  = 4'd6;
  localparam logic [3:0] PH_BDONE = 4'd7;
  localparam logic [3:0] PH_ZWJ   = 4'd8;

  localparam int RES_DEPTH = 4;
  localparam int RPTR_W    = $clog2(RES_DEPTH);
  localparam int RCNT_W    = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    pos_t start;
    pos_t length;
    logic last;
  } result_t;

  logic [3:0] phase;
  pos_t       cluster_begin;
  pos_t       committed_end;

  result_t           res_mem [RES_DEPTH];
  logic [RPTR_W-1:0] wr_ptr;
  logic [RPTR_W-1:0] rd_ptr;
  logic [RCNT_W-1:0] res_count;

  logic [3:0] ph;
  pos_t       cb;
  pos_t       ce;
  logic       restart;
  logic       em_lone;
  logic       em_feed;
  logic       em_eot;
  pos_t       lone_b;
  pos_t       lone_e;
  pos_t       feed_b;
  pos_t       feed_e;
  pos_t       eot_b;
  pos_t       eot_e;
  pos_t       s0_b;
  pos_t       s0_e;
  pos_t       s1_b;
  pos_t       s1_e;
  logic [1:0] n_res;
  result_t    r0;
  result_t    r1;
  logic       out_acc;
  result_t    rd;

  function automatic logic open_range(input logic [3:0] p);
    return p >= PH_RI1 && p <= PH_ZWJ;
  endfunction

  always_comb begin
    ph      = phase;
    cb      = cluster_begin;
    ce      = committed_end;
    restart = 1'b0;
    em_lone = 1'b0;
    em_feed = 1'b0;
    em_eot  = 1'b0;
    lone_b  = cluster_begin;
    lone_e  = committed_end;
    feed_b  = cluster_begin;
    feed_e  = committed_end;
    eot_b   = cluster_begin;
    eot_e   = committed_end;

    // An unpaired high surrogate matches nothing, so it only closes or breaks.
    if (head.lone) begin
      em_lone = open_range(ph);
      ph      = PH_IDLE;
    end

    if (head.ev_valid) begin
      feed_b = cb;
      feed_e = ce;
      unique case (ph)
        PH_KEY1: begin
          if (head.cls.vs) begin
            ph = PH_KEY2;
          end else if (head.cls.keycap) begin
            em_feed = 1'b1;
            feed_e  = head.after;
            ph      = PH_IDLE;
          end else begin
            restart = 1'b1;
          end
        end
        PH_KEY2: begin
          if (head.cls.keycap) begin
            em_feed = 1'b1;
            feed_e  = head.after;
            ph      = PH_IDLE;
          end else begin
            restart = 1'b1;
          end
        end
        PH_RI1: begin
          if (head.cls.ri) begin
            em_feed = 1'b1;
            feed_e  = head.after;
            ph      = PH_IDLE;
          end else begin
            em_feed = 1'b1;
            restart = 1'b1;
          end
        end
        PH_BVS, PH_BMOD, PH_BTAG: begin
          if ((ph == PH_BVS && head.cls.vs) ||
              (ph != PH_BTAG && head.cls.modifier)) begin
            ce = head.after;
            ph = PH_BMOD;
          end else if (head.cls.tag) begin
            ce = head.after;
            ph = head.cls.tag_end ? PH_BDONE : PH_BTAG;
          end else if (head.cls.zwj) begin
            ph = PH_ZWJ;
          end else begin
            em_feed = 1'b1;
            restart = 1'b1;
          end
        end
        PH_BDONE: begin
          if (head.cls.zwj) begin
            ph = PH_ZWJ;
          end else begin
            em_feed = 1'b1;
            restart = 1'b1;
          end
        end
        PH_ZWJ: begin
          if (head.cls.base || head.cls.ri || head.cls.keybase) begin
            ce = head.after;
            ph = PH_BVS;
          end else begin
            em_feed = 1'b1;
            restart = 1'b1;
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase

      if (restart) begin
        ph = PH_IDLE;
        if (head.cls.keybase) begin
          ph = PH_KEY1;
          cb = head.start;
        end else if (head.cls.ri) begin
          ph = PH_RI1;
          cb = head.start;
          ce = head.after;
        end else if (head.cls.base) begin
          ph = PH_BVS;
          cb = head.start;
          ce = head.after;
        end
      end
    end

    // End of text reports an open cluster and drops a pending keycap.
    if (head.eot) begin
      em_eot = open_range(ph);
      eot_b  = cb;
      eot_e  = ce;
      ph     = PH_IDLE;
      cb     = '0;
      ce     = '0;
    end
  end

  always_comb begin
    n_res = 2'(em_lone) + 2'(em_feed) + 2'(em_eot);
    s0_b  = em_lone ? lone_b : (em_feed ? feed_b : eot_b);
    s0_e  = em_lone ? lone_e : (em_feed ? feed_e : eot_e);
    s1_b  = (em_lone && em_feed) ? feed_b : eot_b;
    s1_e  = (em_lone && em_feed) ? feed_e : eot_e;
    r0.start  = s0_b;
    r0.length = s0_e - s0_b;
    r0.last   = n_res == 2'd1;
    r1.start  = s1_b;
    r1.length = s1_e - s1_b;
    r1.last   = 1'b1;
  end

  // A code unit is taken only when the buffer has room for two results.
  assign pop     = !q_empty && (res_count <= RCNT_W'(RES_DEPTH - 2));
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign rd            = res_mem[rd_ptr];
  assign m_axis_tvalid = res_count != '0;
  assign m_axis_tdata  = {32'(rd.length), 32'(rd.start)};
  assign m_axis_tlast  = rd.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      cluster_begin <= '0;
      committed_end <= '0;
    end else if (pop) begin
      phase         <= ph;
      cluster_begin <= cb;
      committed_end <= ce;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && n_res != 2'd0) begin
      res_mem[wr_ptr] <= r0;
    end
    if (pop && n_res == 2'd2) begin
      res_mem[wr_ptr + RPTR_W'(1)] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      res_count <= '0;
    end else begin
      if (pop) begin
        wr_ptr <= wr_ptr + RPTR_W'(n_res);
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + RPTR_W'(1);
      end
      res_count <= res_count + (pop ? RCNT_W'(n_res) : '0) - RCNT_W'(out_acc);
    end
  end

  `ECS_ASSERT_ALWAYS(a_res_bound, res_count <= RCNT_W'(RES_DEPTH))
  `ECS_ASSERT_NEXT(a_eot_idle, pop && head.eot, phase == PH_IDLE && cluster_begin == '0)
  `ECS_ASSERT_NEXT(a_res_hold, !pop && !out_acc, $stable(res_count) && $stable(rd_ptr))

endmodule

`default_nettype wire

// ----- rtl/core/emoji_cluster_segmenter.sv -----
// Emoji cluster segmenter top level.
//
// Code units of a UTF-16 text enter on the s_axis channel, one per request:
// tdata holds the code unit and tlast marks the last unit of the text.
// Each emoji cluster found leaves on the m_axis channel as one request:
// tdata holds the start index (low 32 bits) and the length in code units
// (high 32 bits); tlast marks the final range caused by one input unit.
// The block takes one code unit per cycle while the queue has room. A range
// passes through the queue and the result buffer and leaves at one range
// per cycle while the receiver is ready; two ranges from one unit leave in
// turn. The front end tracks unit positions and surrogate pairs and feeds a
// four-entry queue; the back end runs the cluster parser and holds up to
// four ranges, and pauses the queue while under two places are free there.
// When the receiver stalls, ranges wait in the result buffer, then the queue
// fills and s_axis_tready drops. Reset empties both buffers, clears the unit
// position and returns the parser to idle; the input is ready the cycle after.
`default_nettype none

module emoji_cluster_segmenter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // code_unit
  input  wire logic        s_axis_tlast,  // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // range_start, range_length
  output logic             m_axis_tlast   // last_result
);
  import ecs_pkg::*;

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  q_entry_t q_in;
  q_entry_t q_head;

  ecs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .push          (push),
    .entry         (q_in),
    .q_full        (q_full)
  );

  ecs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_in),
    .full  (q_full),
    .pop   (pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  ecs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .head          (q_head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- tb/emoji_cluster_segmenter_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench that streams UTF-16 texts into the segmenter and checks each range.
module emoji_cluster_segmenter_tb;
  import ecs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [20:0] ZWJ_CP = 21'h0200D;
  localparam logic [20:0] KEYCAP_CP = 21'h020E3;
  localparam logic [20:0] TAG_CANCEL_CP = 21'hE007F;
  localparam logic [5:0] HIGH_SURR_TOP = 6'b110110;
  localparam logic [5:0] LOW_SURR_TOP = 6'b110111;

  typedef enum logic [3:0] {
    SEG_IDLE, SEG_KEY, SEG_KEY_VS, SEG_FLAG, SEG_BASE, SEG_BASE_MOD, SEG_TAGS,
    SEG_TAGS_DONE, SEG_JOINER
  } seg_phase_t;

  typedef enum int {
    TOK_EMOJI, TOK_KEYCAP, TOK_FLAG, TOK_TEXT, TOK_LONE_HIGH, TOK_STRAY, TOK_RAW
  } token_t;

  typedef struct packed {
    pos_t start;
    pos_t length;
    logic last;
  } cluster_range_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = 16'h0000;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tlast;

  // Predictor state.
  pos_t seg_pos;
  pos_t seg_begin;
  pos_t seg_end;
  seg_phase_t seg_phase;
  logic [9:0] seg_high;
  logic seg_high_held;

  cluster_range_t step_ranges[$];
  cluster_range_t expected_ranges[$];
  logic [15:0] text_buf[$];

  int fail_count = 0;
  int units_sent = 0;
  int unsigned cycle_count = 0;
  int stall_left = 0;
  bit idle_on = 1'b0;

  emoji_cluster_segmenter DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("emoji_cluster_segmenter_tb: FAIL");
      $finish;
    end
  end

  // Receiver back-pressure: random bursts of stalled cycles while idle_on is set.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cluster_range_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (expected_ranges.size() == 0) begin
        $error("unexpected range: start %0d, length %0d", m_axis_tdata[31:0],
               m_axis_tdata[63:32]);
        fail_count++;
      end else begin
        want = expected_ranges.pop_front();
        if (m_axis_tdata[31:0] !== want.start) begin
          $error("range_start: expected %0d, got %0d", want.start, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[63:32] !== want.length) begin
          $error("range_length: expected %0d, got %0d", want.length, m_axis_tdata[63:32]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_result: expected %0d, got %0d", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  function automatic bit cp_is_selector(input logic [20:0] cp);
    return cp == 21'h0FE0E || cp == 21'h0FE0F || (cp >= 21'hE0100 && cp <= 21'hE01EF);
  endfunction

  function automatic bit cp_is_flag_half(input logic [20:0] cp);
    return cp >= 21'h1F1E6 && cp <= 21'h1F1FF;
  endfunction

  function automatic bit cp_is_key_base(input logic [20:0] cp);
    return (cp >= 21'h30 && cp <= 21'h39) || cp == 21'h23 || cp == 21'h2A;
  endfunction

  function automatic bit cp_is_skin_tone(input logic [20:0] cp);
    return cp >= 21'h1F3FB && cp <= 21'h1F3FF;
  endfunction

  function automatic bit cp_is_tag(input logic [20:0] cp);
    return cp >= 21'hE0020 && cp <= TAG_CANCEL_CP;
  endfunction

  function automatic bit cp_is_pictograph(input logic [20:0] cp);
    return (cp >= 21'h1F000 && cp <= 21'h1FAFF) || (cp >= 21'h1FC00 && cp <= 21'h1FFFF) ||
           (cp >= 21'h02600 && cp <= 21'h027BF) || (cp >= 21'h02B00 && cp <= 21'h02BFF) ||
           (cp >= 21'h02300 && cp <= 21'h023FF) ||
           cp == 21'h000A9 || cp == 21'h000AE || cp == 21'h0203C || cp == 21'h02049 ||
           cp == 21'h02122 || cp == 21'h02139 || cp == 21'h024C2 || cp == 21'h03030 ||
           cp == 21'h0303D || cp == 21'h03297 || cp == 21'h03299 ||
           (cp >= 21'h02194 && cp <= 21'h021AA) || (cp >= 21'h025AA && cp <= 21'h025AB) ||
           cp == 21'h025B6 || cp == 21'h025C0 || (cp >= 21'h025FB && cp <= 21'h025FE);
  endfunction

  function automatic void seg_reset();
    seg_pos = '0;
    seg_begin = '0;
    seg_end = '0;
    seg_phase = SEG_IDLE;
    seg_high = '0;
    seg_high_held = 1'b0;
  endfunction

  function automatic void record_range(input pos_t first, input pos_t past);
    step_ranges.push_back('{start: first, length: past - first, last: 1'b0});
  endfunction

  function automatic void seg_open(input logic [20:0] cp, input pos_t start, input pos_t after);
    seg_phase = SEG_IDLE;
    if (cp_is_key_base(cp)) begin
      seg_phase = SEG_KEY;
      seg_begin = start;
    end else if (cp_is_flag_half(cp)) begin
      seg_phase = SEG_FLAG;
      seg_begin = start;
      seg_end = after;
    end else if (cp_is_pictograph(cp)) begin
      seg_phase = SEG_BASE;
      seg_begin = start;
      seg_end = after;
    end
  endfunction

  function automatic void seg_close_reopen(input logic [20:0] cp, input pos_t start,
                                           input pos_t after);
    record_range(seg_begin, seg_end);
    seg_open(cp, start, after);
  endfunction

  function automatic bit seg_take_tag(input logic [20:0] cp, input pos_t after);
    if (!cp_is_tag(cp)) return 1'b0;
    seg_end = after;
    seg_phase = (cp == TAG_CANCEL_CP) ? SEG_TAGS_DONE : SEG_TAGS;
    return 1'b1;
  endfunction

  function automatic void seg_feed(input logic [20:0] cp, input pos_t start, input pos_t after);
    case (seg_phase)
      SEG_KEY: begin
        if (cp_is_selector(cp)) seg_phase = SEG_KEY_VS;
        else if (cp == KEYCAP_CP) begin
          record_range(seg_begin, after);
          seg_phase = SEG_IDLE;
        end else seg_open(cp, start, after);
      end
      SEG_KEY_VS: begin
        if (cp == KEYCAP_CP) begin
          record_range(seg_begin, after);
          seg_phase = SEG_IDLE;
        end else seg_open(cp, start, after);
      end
      SEG_FLAG: begin
        if (cp_is_flag_half(cp)) begin
          record_range(seg_begin, after);
          seg_phase = SEG_IDLE;
        end else seg_close_reopen(cp, start, after);
      end
      SEG_BASE, SEG_BASE_MOD: begin
        // A variation selector is only taken right after the base.
        if ((seg_phase == SEG_BASE && cp_is_selector(cp)) || cp_is_skin_tone(cp)) begin
          seg_end = after;
          seg_phase = SEG_BASE_MOD;
        end else if (seg_take_tag(cp, after)) begin
        end else if (cp == ZWJ_CP) seg_phase = SEG_JOINER;
        else seg_close_reopen(cp, start, after);
      end
      SEG_TAGS: begin
        if (seg_take_tag(cp, after)) begin
        end else if (cp == ZWJ_CP) seg_phase = SEG_JOINER;
        else seg_close_reopen(cp, start, after);
      end
      SEG_TAGS_DONE: begin
        if (cp == ZWJ_CP) seg_phase = SEG_JOINER;
        else seg_close_reopen(cp, start, after);
      end
      SEG_JOINER: begin
        if (cp_is_pictograph(cp) || cp_is_flag_half(cp) || cp_is_key_base(cp)) begin
          seg_end = after;
          seg_phase = SEG_BASE;
        end else seg_close_reopen(cp, start, after);
      end
      default: seg_open(cp, start, after);
    endcase
  endfunction

  // Works out the ranges that one accepted code unit closes.
  function automatic void segment_unit(input logic [15:0] unit, input logic eot);
    pos_t here;
    pos_t prior;
    pos_t following;
    logic paired;
    cluster_range_t r;
    here = seg_pos;
    prior = here - pos_t'(1);
    following = here + pos_t'(1);
    paired = 1'b0;
    step_ranges.delete();
    if (seg_high_held) begin
      seg_high_held = 1'b0;
      if (unit[15:10] == LOW_SURR_TOP) begin
        seg_feed(21'h10000 + {1'b0, seg_high, unit[9:0]}, prior, following);
        paired = 1'b1;
      end else begin
        // The held high surrogate had no partner: it is a code point of its own.
        seg_feed({5'd0, HIGH_SURR_TOP, seg_high}, prior, here);
      end
    end
    if (!paired) begin
      if (unit[15:10] == HIGH_SURR_TOP && !eot) begin
        seg_high = unit[9:0];
        seg_high_held = 1'b1;
      end else begin
        seg_feed({5'd0, unit}, here, following);
      end
    end
    if (eot) begin
      if (seg_phase != SEG_IDLE && seg_phase != SEG_KEY && seg_phase != SEG_KEY_VS)
        record_range(seg_begin, seg_end);
      seg_reset();
    end else begin
      seg_pos = following;
    end
    for (int i = 0; i < step_ranges.size(); i++) begin
      r = step_ranges[i];
      r.last = (i == step_ranges.size() - 1);
      expected_ranges.push_back(r);
    end
  endfunction

  function automatic void push_cp(input int unsigned cp);
    int unsigned off;
    if (cp >= 32'h10000) begin
      off = cp - 32'h10000;
      text_buf.push_back(16'(32'hD800 + (off >> 10)));
      text_buf.push_back(16'(32'hDC00 + (off & 32'h3FF)));
    end else begin
      text_buf.push_back(16'(cp));
    end
  endfunction

  function automatic int unsigned pick_selector();
    case ($urandom_range(0, 2))
      0: return 32'hFE0E;
      1: return 32'hFE0F;
      default: return 32'hE0100 + $urandom_range(0, 32'hEF);
    endcase
  endfunction

  function automatic int unsigned pick_flag_half();
    return 32'h1F1E6 + $urandom_range(0, 25);
  endfunction

  function automatic int unsigned pick_key_base();
    int n;
    n = $urandom_range(0, 11);
    if (n == 10) return 32'h23;
    if (n == 11) return 32'h2A;
    return 32'h30 + n;
  endfunction

  function automatic int unsigned pick_base();
    case ($urandom_range(0, 7))
      0, 1: return 32'h1F000 + $urandom_range(0, 32'hAFF);
      2: return 32'h1FC00 + $urandom_range(0, 32'h3FF);
      3: return 32'h2600 + $urandom_range(0, 32'h1BF);
      4: return ($urandom_range(0, 1) ? 32'h2B00 : 32'h2300) + $urandom_range(0, 32'hFF);
      5: return 32'h2194 + $urandom_range(0, 32'h16);
      6: return 32'h25FB + $urandom_range(0, 3);
      default: begin
        case ($urandom_range(0, 14))
          0: return 32'h00A9;
          1: return 32'h00AE;
          2: return 32'h203C;
          3: return 32'h2049;
          4: return 32'h2122;
          5: return 32'h2139;
          6: return 32'h24C2;
          7: return 32'h3030;
          8: return 32'h303D;
          9: return 32'h3297;
          10: return 32'h3299;
          11: return 32'h25AA;
          12: return 32'h25AB;
          13: return 32'h25B6;
          default: return 32'h25C0;
        endcase
      end
    endcase
  endfunction

  // Optional selector, skin tones and a tag run after a base.
  function automatic void add_tail();
    if ($urandom_range(0, 2) == 0) push_cp(pick_selector());
    repeat ($urandom_range(0, 1) * $urandom_range(0, 2))
      push_cp(32'h1F3FB + $urandom_range(0, 4));
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) push_cp(32'hE0020 + $urandom_range(0, 32'h5E));
      if ($urandom_range(0, 3) != 0) push_cp(TAG_CANCEL_CP);
    end
  endfunction

  function automatic void add_token();
    token_t tok;
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 5) tok = TOK_EMOJI;
    else if (pick < 8) tok = TOK_KEYCAP;
    else if (pick < 10) tok = TOK_FLAG;
    else if (pick < 12) tok = TOK_TEXT;
    else tok = token_t'($urandom_range(TOK_LONE_HIGH, TOK_RAW));
    case (tok)
      TOK_EMOJI: begin
        push_cp(pick_base());
        add_tail();
        repeat ($urandom_range(0, 2)) begin
          push_cp(ZWJ_CP);
          case ($urandom_range(0, 4))
            0, 1: begin
              push_cp(pick_base());
              add_tail();
            end
            2: push_cp(pick_flag_half());
            3: push_cp(pick_key_base());
            default: push_cp($urandom_range(32'h41, 32'h5A));
          endcase
        end
      end
      TOK_KEYCAP: begin
        push_cp(pick_key_base());
        if ($urandom_range(0, 1) != 0) push_cp(pick_selector());
        if ($urandom_range(0, 3) != 0) push_cp(KEYCAP_CP);
        else push_cp($urandom_range(32'h20, 32'h7E));
      end
      TOK_FLAG: begin
        push_cp(pick_flag_half());
        if ($urandom_range(0, 3) != 0) push_cp(pick_flag_half());
      end
      TOK_TEXT: push_cp($urandom_range(32'h20, 32'h7E));
      TOK_LONE_HIGH: push_cp($urandom_range(32'hD800, 32'hDBFF));
      TOK_STRAY: begin
        case ($urandom_range(0, 4))
          0: push_cp($urandom_range(32'hDC00, 32'hDFFF));
          1: push_cp(ZWJ_CP);
          2: push_cp(pick_selector());
          3: push_cp(KEYCAP_CP);
          default: push_cp(32'h1F3FB + $urandom_range(0, 4));
        endcase
      end
      default: push_cp($urandom_range(0, 32'hFFFF));
    endcase
  endfunction

  function automatic void build_text();
    repeat ($urandom_range(1, 8)) add_token();
  endfunction

  // Offers one code unit and holds the request until the block takes it.
  task automatic send_unit(input logic [15:0] unit, input logic eot);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= unit;
    s_axis_tlast <= eot;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    segment_unit(unit, eot);
    units_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic send_buffer();
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) send_unit(text_buf[i], i == n - 1);
    text_buf.delete();
  endtask

  task automatic wait_for_ranges();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_ranges.size() != 0);
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    // Keycaps with and without selector, a broken keycap into a flag, a toned
    // ZWJ sequence, a dangling ZWJ, a lone high surrogate, a tag flag, and a
    // high surrogate carrying the end mark.
    text_buf = '{16'h0031, 16'hFE0F, 16'h20E3, 16'h0023, 16'h20E3,
                 16'h002A, 16'hD83C, 16'hDDFA, 16'hD83C, 16'hDDF8,
                 16'hD83D, 16'hDC68, 16'hD83C, 16'hDFFD, 16'h200D, 16'hD83D, 16'hDC69,
                 16'h200D, 16'hD83D, 16'h0000,
                 16'hD83C, 16'hDFF4, 16'hDB40, 16'hDC67, 16'hDB40, 16'hDC7F,
                 16'h263A, 16'hDBFF};
    send_buffer();
    // A keycap still pending at the end of the text is dropped.
    text_buf = '{16'hFFFF, 16'h0035};
    send_buffer();
  endtask

  task automatic test_random_texts(input int stop_at);
    while (units_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      build_text();
      send_buffer();
    end
  endtask

  task automatic test_drain_pause();
    idle_on = 1'b1;
    repeat (8) begin
      build_text();
      send_buffer();
      wait_for_ranges();
    end
  endtask

  task automatic test_noise(input int stop_at);
    logic [15:0] unit;
    idle_on = 1'b1;
    while (units_sent < stop_at) begin
      if ($urandom_range(0, 2) == 0) unit = 16'($urandom_range(32'hD800, 32'hDFFF));
      else unit = 16'($urandom());
      send_unit(unit, $urandom_range(0, 39) == 0);
    end
  endtask

  task automatic test_calm(input int stop_at);
    idle_on = 1'b0;
    while (units_sent < stop_at) begin
      build_text();
      send_buffer();
    end
  endtask

  initial begin
    seg_reset();
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_texts(1000);
    test_drain_pause();
    test_noise(1450);
    test_calm(1850);
    idle_on = 1'b0;
    wait_for_ranges();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_ranges.size() == 0) begin
      $display("emoji_cluster_segmenter_tb: PASS");
    end else begin
      $display("emoji_cluster_segmenter_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/ecs_pkg.sv
rtl/core/ecs_front.sv
rtl/core/ecs_queue.sv
rtl/core/ecs_back.sv
rtl/core/emoji_cluster_segmenter.sv
tb/emoji_cluster_segmenter_tb.sv
